>>> hw/rtl/ftst_pkg.sv
// Package for the fake TCP sequence tracker: queue entry and result types,
// link flag codes and header constants. No dependencies.
`timescale 1ns / 1ps

package ftst_pkg;

    // Link flag codes: bit 0 = SYN, bit 1 = ACK
    localparam logic [1:0] FLAG_SYN = 2'b01;
    localparam logic [1:0] FLAG_ACK = 2'b10;
    localparam logic [1:0] FLAG_SYN_ACK = 2'b11;

    // Request kinds carried on tuser
    localparam logic REQ_RECV = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    localparam logic [31:0] SEQ_START = 32'h0000_0100;
    localparam logic [15:0] MIN_PAYLOAD = 16'd20;
    localparam logic [11:0] TCP_HDR_BYTES = 12'd20;
    localparam logic [11:0] OPT_BYTES = 12'd4;
    localparam logic [13:0] IP_TCP_BYTES = 14'd40;
    localparam logic [2:0] OFFSET_PLAIN = 3'd5;
    localparam logic [2:0] OFFSET_OPT = 3'd6;

    // Classified item passed from front to back
    typedef struct packed {
        logic        req_type;
        logic        rx_ok;        // port matches and payload long enough
        logic [15:0] deliver_len;  // min(payload, capacity)
        logic        seg_syn;
        logic        seg_ack;
        logic [31:0] seg_end;      // seq + payload length
        logic [10:0] send_len;
        logic        fit_plain;    // send fits the MTU without option
        logic        fit_opt;      // send fits the MTU with option
    } t_item;

    // One result item
    typedef struct packed {
        logic        accepted;
        logic [15:0] deliver_len;
        logic [31:0] hdr_seq;
        logic [31:0] hdr_ack;
        logic        hdr_syn;
        logic        hdr_ackflag;
        logic [2:0]  hdr_offset;
        logic        has_option;
        logic [11:0] wire_len;
    } t_result;

    // Modulo 2^32 order: a before b when bit 31 of a - b is set
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

>>> hw/rtl/ftst_front.sv
// Front end: unpacks the input item and classifies it (port and length
// checks, MTU fit, segment end). Depends on ftst_pkg.
`timescale 1ns / 1ps

module ftst_front #(
    parameter int LINK_MTU    = 1500,
    parameter int TUNNEL_PORT = 16448
) (
    input  logic         i_req_type,
    input  logic [15:0]  i_seg_dst_port,
    input  logic         i_seg_syn,
    input  logic         i_seg_ack,
    input  logic [31:0]  i_seg_seq,
    input  logic [15:0]  i_seg_payload_len,
    input  logic [15:0]  i_recv_capacity,
    input  logic [10:0]  i_send_len,
    output ftst_pkg::t_item o_item
);

    localparam logic [15:0] PORT = 16'(TUNNEL_PORT);
    localparam logic [13:0] MTU  = 14'(LINK_MTU);

    logic [13:0] w_len_plain;
    logic [13:0] w_len_opt;

    // Bytes on the link with and without the option
    assign w_len_plain = ftst_pkg::IP_TCP_BYTES + 14'(i_send_len);
    assign w_len_opt   = w_len_plain + 14'(ftst_pkg::OPT_BYTES);

    always_comb begin
        o_item.req_type    = i_req_type;
        o_item.rx_ok       = (i_seg_dst_port == PORT) &&
                             (i_seg_payload_len > ftst_pkg::MIN_PAYLOAD);
        o_item.deliver_len = (i_seg_payload_len < i_recv_capacity) ?
                             i_seg_payload_len : i_recv_capacity;
        o_item.seg_syn     = i_seg_syn;
        o_item.seg_ack     = i_seg_ack;
        o_item.seg_end     = i_seg_seq + 32'(i_seg_payload_len);
        o_item.send_len    = i_send_len;
        o_item.fit_plain   = (w_len_plain <= MTU);
        o_item.fit_opt     = (w_len_opt <= MTU);
    end

endmodule

>>> hw/rtl/ftst_queue.sv
// Two-entry queue between front and back so that each side stalls alone.
// Depends on ftst_pkg.
`timescale 1ns / 1ps

module ftst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ftst_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ftst_pkg::t_item o_item
);

    ftst_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/ftst_back.sv
// Back end: holds the link sequence state, applies receive and send rules
// and registers one result. Depends on ftst_pkg.
`timescale 1ns / 1ps

module ftst_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ftst_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ftst_pkg::t_result o_result
);

    logic [31:0]       r_ack_point;
    logic [31:0]       r_next_seq;
    logic [31:0]       r_max_seq;
    logic [1:0]        r_flags;
    logic              r_out_valid;
    ftst_pkg::t_result r_out;

    logic [31:0]       n_ack_point;
    logic [31:0]       n_next_seq;
    logic [31:0]       n_max_seq;
    logic [1:0]        n_flags;
    ftst_pkg::t_result n_out;

    logic              w_syn;
    logic              w_fit;
    logic [31:0]       w_ns0;
    logic [31:0]       w_ms0;
    logic [31:0]       w_nl;
    logic [31:0]       w_len32;
    logic [11:0]       w_opt;

    // Take an entry whenever the output slot is free or being emptied
    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Send path terms
    assign w_syn   = r_flags[0];
    assign w_fit   = w_syn ? i_item.fit_opt : i_item.fit_plain;
    assign w_ns0   = w_syn ? ftst_pkg::SEQ_START : r_next_seq;
    assign w_ms0   = (r_flags == ftst_pkg::FLAG_SYN) ? ftst_pkg::SEQ_START : r_max_seq;
    assign w_len32 = 32'(i_item.send_len);
    assign w_nl    = w_ns0 + w_len32;
    assign w_opt   = w_syn ? ftst_pkg::OPT_BYTES : 12'd0;

    always_comb begin
        n_ack_point = r_ack_point;
        n_next_seq  = r_next_seq;
        n_max_seq   = r_max_seq;
        n_flags     = r_flags;
        n_out       = '0;
        if (i_item.req_type == ftst_pkg::REQ_RECV) begin
            // Received segment: SYN, SYN-ACK, then plain ACK rules
            if (i_item.rx_ok) begin
                n_out.accepted    = 1'b1;
                n_out.deliver_len = i_item.deliver_len;
                priority if (i_item.seg_syn && !i_item.seg_ack) begin
                    n_flags     = ftst_pkg::FLAG_SYN_ACK;
                    n_next_seq  = ftst_pkg::SEQ_START;
                    n_max_seq   = ftst_pkg::SEQ_START;
                    n_ack_point = i_item.seg_end + 32'd1;
                end else if (i_item.seg_syn && i_item.seg_ack &&
                             r_flags != ftst_pkg::FLAG_ACK) begin
                    n_flags     = ftst_pkg::FLAG_ACK;
                    n_ack_point = i_item.seg_end + 32'd1;
                end else if (ftst_pkg::seq_before(r_ack_point, i_item.seg_end)) begin
                    n_flags     = ftst_pkg::FLAG_ACK;
                    n_ack_point = i_item.seg_end;
                end else begin
                    n_flags     = ftst_pkg::FLAG_ACK;
                end
            end
        end else begin
            // Send request: header fields, then scrambled sequence advance
            if (w_fit) begin
                n_out.accepted    = 1'b1;
                n_out.hdr_seq     = w_syn ? (ftst_pkg::SEQ_START - 32'd1) : r_next_seq;
                n_out.hdr_ack     = r_ack_point;
                n_out.hdr_syn     = w_syn;
                n_out.hdr_ackflag = r_flags[1];
                n_out.hdr_offset  = w_syn ? ftst_pkg::OFFSET_OPT : ftst_pkg::OFFSET_PLAIN;
                n_out.has_option  = w_syn;
                n_out.wire_len    = ftst_pkg::TCP_HDR_BYTES + w_opt + 12'(i_item.send_len);
                priority if (ftst_pkg::seq_before(w_nl, w_ms0)) begin
                    n_next_seq = w_ms0;
                    n_max_seq  = w_ms0;
                end else if (ftst_pkg::seq_before(w_ms0, w_ns0)) begin
                    n_max_seq  = w_nl;
                    n_next_seq = w_ms0;
                end else begin
                    n_max_seq  = w_nl;
                    n_next_seq = w_nl + w_len32;
                end
            end
        end
    end

    // Link state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_point <= '0;
            r_next_seq  <= ftst_pkg::SEQ_START;
            r_max_seq   <= ftst_pkg::SEQ_START;
            r_flags     <= ftst_pkg::FLAG_SYN;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ack_point <= n_ack_point;
                r_next_seq  <= n_next_seq;
                r_max_seq   <= n_max_seq;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/fake_tcp_sequence_tracker.sv
// Top level of the fake TCP sequence tracker: front classifier, queue and
// sequence back end. Depends on ftst_pkg, ftst_front, ftst_queue, ftst_back.
//
//  Channel  | Direction | Carries
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | receive segments and send requests (tuser = kind)
//  m_axis   | out       | one result item per input item
//
// One item per cycle while m_axis_tready stays high; each accepted item is
// written into the queue and then into the result register, which drives
// m_axis_tvalid. The back end updates the link state once per item.
// Synchronous active-low reset clears the link state, queue and output valid.
// A stalled output fills the two-entry queue, after which s_axis_tready drops.
`timescale 1ns / 1ps

module fake_tcp_sequence_tracker #(
    parameter int LINK_MTU    = 1500,
    parameter int TUNNEL_PORT = 16448
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seg_dst_port[15:0], seg_syn[16], seg_ack[17], seg_seq[49:18],
    // seg_payload_len[65:50], recv_capacity[81:66], send_len[92:82]
    input  logic [95:0]  s_axis_tdata,
    // req_type[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted[0], deliver_len[16:1], hdr_seq[48:17], hdr_ack[80:49],
    // hdr_syn[81], hdr_ackflag[82], hdr_offset[85:83], has_option[86],
    // wire_len[98:87]
    output logic [103:0] m_axis_tdata
);

    ftst_pkg::t_item   w_front_item;
    ftst_pkg::t_item   w_q_item;
    ftst_pkg::t_result w_result;
    logic              w_full;
    logic              w_push;
    logic              w_pop;
    logic              w_q_valid;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // Classification
    ftst_front #(
        .LINK_MTU    (LINK_MTU),
        .TUNNEL_PORT (TUNNEL_PORT)
    ) u_front (
        .i_req_type        (s_axis_tuser),
        .i_seg_dst_port    (s_axis_tdata[15:0]),
        .i_seg_syn         (s_axis_tdata[16]),
        .i_seg_ack         (s_axis_tdata[17]),
        .i_seg_seq         (s_axis_tdata[49:18]),
        .i_seg_payload_len (s_axis_tdata[65:50]),
        .i_recv_capacity   (s_axis_tdata[81:66]),
        .i_send_len        (s_axis_tdata[92:82]),
        .o_item            (w_front_item)
    );

    // Decoupling queue
    ftst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Sequence state and result register
    ftst_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // Output packing, lowest field first
    assign m_axis_tdata = {5'd0,
                           w_result.wire_len,
                           w_result.has_option,
                           w_result.hdr_offset,
                           w_result.hdr_ackflag,
                           w_result.hdr_syn,
                           w_result.hdr_ack,
                           w_result.hdr_seq,
                           w_result.deliver_len,
                           w_result.accepted};

endmodule
